// ===== rtl/descending_selection_sort_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the descending selection sort
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DESCENDING_SELECTION_SORT_ASSERT_SVH
`define DESCENDING_SELECTION_SORT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define DSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Sizes, types and state codes shared by the descending selection sort.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int MAX_LINES  = 64;
    localparam int SCORE_BITS = 16;
    localparam int TAG_BITS   = 12;

    localparam int ADDR_BITS    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int COUNT_BITS   = $clog2(MAX_LINES + 1);
    localparam int ENTRY_BITS   = SCORE_BITS + TAG_BITS;
    localparam int STREAM_BITS  = ((ENTRY_BITS + 7) / 8) * 8;

    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    // One stored line: score in the low bits, tag above it.
    typedef struct packed {
        logic [TAG_BITS-1:0]   tag;
        logic [SCORE_BITS-1:0] score;
    } entry_t;

    // Access request from the sequencer to the line memory.
    typedef struct packed {
        logic   we;
        addr_t  waddr;
        entry_t wdata;
        logic   re;
        addr_t  raddr;
    } ram_req_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/dss_ram.sv =====
// ----------------------------------------------------------------------------
// dss_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dss_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 28
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/dss_ctrl.sv =====
// ----------------------------------------------------------------------------
// dss_ctrl
// Sequencer: loads lines into memory, runs the selection passes over the
// memory read port, and holds the output beat register.
// ----------------------------------------------------------------------------
module dss_ctrl
    import dss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    // Input beats.
    input  logic     in_valid,
    output logic     in_ready,
    input  entry_t   in_entry,
    input  logic     in_last,
    // Output beats.
    output logic     out_valid,
    input  logic     out_ready,
    output entry_t   out_entry,
    output logic     out_last,
    output logic     out_ovf,
    // Line memory.
    output ram_req_t ram_req,
    input  entry_t   ram_rdata
);

    state_t state_reg, state_next;
    count_t count_reg, count_next;
    count_t n_reg, n_next;
    addr_t  i_reg, i_next;
    addr_t  j_reg, j_next;
    logic   ovf_reg, ovf_next;
    logic   rv_reg, rv_next;
    logic   first_reg, first_next;
    logic   out_valid_reg, out_valid_next;

    addr_t  ridx_reg, ridx_next;
    entry_t best_reg, best_next;
    addr_t  best_idx_reg, best_idx_next;
    entry_t first_entry_reg, first_entry_next;
    entry_t out_entry_reg, out_entry_next;
    logic   out_last_reg, out_last_next;
    logic   out_ovf_reg, out_ovf_next;

    logic   in_fire;
    logic   has_room;
    logic   scan_end;
    logic   pass_last;
    logic   out_free;

    assign in_ready  = (state_reg == ST_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign has_room  = (count_reg < COUNT_BITS'(MAX_LINES));
    assign scan_end  = ((COUNT_BITS'(j_reg) + COUNT_BITS'(1)) == n_reg);
    assign pass_last = ((COUNT_BITS'(i_reg) + COUNT_BITS'(1)) == n_reg);
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_entry = out_entry_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            ovf_reg       <= 1'b0;
            rv_reg        <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            ovf_reg       <= ovf_next;
            rv_reg        <= rv_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ridx_reg        <= ridx_next;
        best_reg        <= best_next;
        best_idx_reg    <= best_idx_next;
        first_entry_reg <= first_entry_next;
        out_entry_reg   <= out_entry_next;
        out_last_reg    <= out_last_next;
        out_ovf_reg     <= out_ovf_next;
    end

    // Running maximum over the data returned by the read port.
    always_comb
    begin
        best_next        = best_reg;
        best_idx_next    = best_idx_reg;
        first_entry_next = first_entry_reg;
        if (rv_reg)
        begin
            if (first_reg)
            begin
                best_next        = ram_rdata;
                best_idx_next    = ridx_reg;
                first_entry_next = ram_rdata;
            end
            else if (best_reg.score < ram_rdata.score)
            begin
                best_next     = ram_rdata;
                best_idx_next = ridx_reg;
            end
        end
    end

    // Next state, memory requests and output register.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ovf_next       = ovf_reg;
        rv_next        = 1'b0;
        first_next     = 1'b0;
        ridx_next      = j_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_entry_next = out_entry_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = count_reg[ADDR_BITS-1:0];
        ram_req.wdata = in_entry;
        ram_req.re    = 1'b0;
        ram_req.raddr = j_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    // Store in arrival order while there is room.
                    if (has_room)
                    begin
                        ram_req.we = 1'b1;
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        n_next     = has_room ? (count_reg + COUNT_BITS'(1)) : count_reg;
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // One read per cycle over positions i to n-1.
                ram_req.re = 1'b1;
                rv_next    = 1'b1;
                first_next = (j_reg == i_reg);
                if (scan_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + ADDR_BITS'(1);
                end
            end

            ST_DRAIN:
            begin
                // The last read of the pass returns here.
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                // The maximum is final for position i: send it, and move the
                // old occupant of position i into the maximum's slot.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_entry_next = best_reg;
                    out_last_next  = pass_last;
                    out_ovf_next   = ovf_reg;
                    ram_req.we     = 1'b1;
                    ram_req.waddr  = best_idx_reg;
                    ram_req.wdata  = first_entry_reg;
                    if (pass_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + ADDR_BITS'(1);
                        j_next     = i_reg + ADDR_BITS'(1);
                        state_next = ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/descending_selection_sort.sv =====
// ----------------------------------------------------------------------------
// descending_selection_sort
// Collects a set of scored lines and returns them in descending score order.
// ----------------------------------------------------------------------------
// Lines are taken one beat per cycle into a 64-entry memory until the beat
// with tlast; beats beyond capacity are dropped and flag overflow on every
// result of that set. The set of n lines is then sorted by selection passes:
// pass i reads positions i to n-1 through the single memory read port, one
// per cycle, then waits for the last read to return and emits its maximum;
// an output stall holds the pass at that point. The input is not ready
// while a set is sorted and returned. Ties go to the earliest position in
// each pass. No clearing pass follows reset.
module descending_selection_sort
    import dss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input lines.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [STREAM_BITS-1:0] s_tdata,   // line_value, line_tag, zero pad
    input  logic                   s_tlast,   // last_in
    // Sorted lines.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [STREAM_BITS-1:0] m_tdata,   // sorted_value, sorted_tag, zero pad
    output logic                   m_tlast,   // last_out
    output logic                   m_tuser    // overflow
);

    ram_req_t ram_req;
    entry_t   ram_rdata;
    entry_t   in_entry;
    entry_t   out_entry;
    logic [ENTRY_BITS-1:0] rdata_bits;

    assign in_entry  = entry_t'(s_tdata[ENTRY_BITS-1:0]);
    assign ram_rdata = entry_t'(rdata_bits);
    assign m_tdata   = STREAM_BITS'(out_entry);

    // Sequencer and output register.
    dss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_entry  (in_entry),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (out_entry),
        .out_last  (m_tlast),
        .out_ovf   (m_tuser),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Line memory.
    dss_ram #(
        .DEPTH (MAX_LINES),
        .WIDTH (ENTRY_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (rdata_bits)
    );

endmodule

// ===== rtl/dss_checker.sv =====
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks of the descending selection sort, bound to the top level.
// ----------------------------------------------------------------------------
`include "descending_selection_sort_assert.svh"

module dss_checker
    import dss_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [STREAM_BITS-1:0] m_tdata,
    input logic                   m_tlast,
    input logic                   m_tuser
);

    logic                   in_run_reg;
    logic [SCORE_BITS-1:0]  prev_score_reg;
    logic                   m_fire;
    logic                   s_fire;
    logic [STREAM_BITS+1:0] m_beat;

    assign m_fire = m_tvalid && m_tready;
    assign s_fire = s_tvalid && s_tready;
    assign m_beat = {m_tuser, m_tlast, m_tdata};

    // Track the previous score of the current output run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg <= 1'b0;
        end
        else if (m_fire)
        begin
            in_run_reg <= !m_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_fire)
        begin
            prev_score_reg <= m_tdata[SCORE_BITS-1:0];
        end
    end

    // A stalled output beat holds its payload.
    `DSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_beat))

    // Scores within a run never rise.
    `DSS_ASSERT_SAME(a_descending, m_fire && in_run_reg, m_tdata[SCORE_BITS-1:0] <= prev_score_reg)

    // The beat that closes a set starts the sort, so loading stops.
    `DSS_ASSERT_NEXT(a_sort_starts, s_fire && s_tlast, !s_tready)

    // New output beats appear only while lines are not being loaded.
    `DSS_ASSERT_SAME(a_emit_while_sorting, $rose(m_tvalid), !$past(s_tready))

endmodule

bind descending_selection_sort dss_checker u_dss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== sim/descending_selection_sort_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// descending_selection_sort_test
// Streams sets of scored lines into the sorter and checks every sorted beat.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the line store. It runs the same
// first-greatest selection passes when a set closes, and queues the ranked
// lines that the block should return. Directed sets cover single lines,
// extreme scores and tags, and tied scores. Random sets follow, among them a
// full store and an oversized set whose closing beat is dropped. The sender
// works in bursts and the receiver stalls in changing modes.
// ----------------------------------------------------------------------------

typedef struct {
    logic [dss_pkg::SCORE_BITS-1:0] score;
    logic [dss_pkg::TAG_BITS-1:0]   tag;
    logic                           last;
    logic                           ovf;
} ranked_line_t;

class ranking_board;
    logic [dss_pkg::SCORE_BITS-1:0] held_score[$];
    logic [dss_pkg::TAG_BITS-1:0]   held_tag[$];
    bit                             dropped;
    ranked_line_t                   ranks_due[$];
    int unsigned                    mismatches;

    function new();
        dropped    = 1'b0;
        mismatches = 0;
    endfunction

    // Selection passes in place: the first greatest score from position i
    // onward is swapped into position i.
    function void rank_set();
        int                             best;
        logic [dss_pkg::SCORE_BITS-1:0] score_tmp;
        logic [dss_pkg::TAG_BITS-1:0]   tag_tmp;
        for (int i = 0; i + 1 < held_score.size(); i++)
        begin
            best = i;
            for (int j = i + 1; j < held_score.size(); j++)
            begin
                if (held_score[best] < held_score[j])
                    best = j;
            end
            if (best != i)
            begin
                score_tmp        = held_score[i];
                held_score[i]    = held_score[best];
                held_score[best] = score_tmp;
                tag_tmp          = held_tag[i];
                held_tag[i]      = held_tag[best];
                held_tag[best]   = tag_tmp;
            end
        end
    endfunction

    // One accepted input beat. A closing beat ranks the held lines and
    // queues them as expected output, then empties the store.
    function void note_line(logic [dss_pkg::SCORE_BITS-1:0] score,
                            logic [dss_pkg::TAG_BITS-1:0] tag, logic last);
        ranked_line_t rank;
        if (held_score.size() < dss_pkg::MAX_LINES)
        begin
            held_score.push_back(score);
            held_tag.push_back(tag);
        end
        else
            dropped = 1'b1;
        if (last)
        begin
            rank_set();
            for (int k = 0; k < held_score.size(); k++)
            begin
                rank.score = held_score[k];
                rank.tag   = held_tag[k];
                rank.last  = (k + 1 == held_score.size());
                rank.ovf   = dropped;
                ranks_due.push_back(rank);
            end
            held_score.delete();
            held_tag.delete();
            dropped = 1'b0;
        end
    endfunction

    // One accepted output beat, compared with the oldest expected rank.
    function void check_rank(logic [dss_pkg::SCORE_BITS-1:0] score,
                             logic [dss_pkg::TAG_BITS-1:0] tag, logic last, logic ovf);
        ranked_line_t want;
        if (ranks_due.size() == 0)
        begin
            $display("%0t: unexpected beat, score %0d tag %0d", $time, score, tag);
            mismatches++;
            return;
        end
        want = ranks_due.pop_front();
        if (score !== want.score)
        begin
            $display("%0t: score mismatch, expected %0d, actual %0d", $time, want.score, score);
            mismatches++;
        end
        if (tag !== want.tag)
        begin
            $display("%0t: tag mismatch, expected %0d, actual %0d", $time, want.tag, tag);
            mismatches++;
        end
        if (last !== want.last)
        begin
            $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, last);
            mismatches++;
        end
        if (ovf !== want.ovf)
        begin
            $display("%0t: overflow mismatch, expected %0b, actual %0b", $time, want.ovf, ovf);
            mismatches++;
        end
    endfunction

    function int unsigned outstanding();
        return ranks_due.size();
    endfunction
endclass

module descending_selection_sort_test;
    import dss_pkg::*;

    localparam int RANDOM_LINES = 220;
    localparam int CYCLE_LIMIT  = 400000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [STREAM_BITS-1:0] s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [STREAM_BITS-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    ranking_board board = new();
    int unsigned  cycle_count = 0;
    int unsigned  burst_left  = 0;
    int unsigned  stall_phase = 0;
    int unsigned  stall_mode  = 0;

    descending_selection_sort i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: picks a new stall mode whenever its phase counter runs out.
    always @(posedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_phase <= $urandom_range(8, 64);
        end
        else
            stall_phase <= stall_phase - 1;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= stall_phase[2];
        endcase
    end

    // Every accepted output beat goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_rank(m_tdata[SCORE_BITS-1:0], m_tdata[ENTRY_BITS-1:SCORE_BITS],
                             m_tlast, m_tuser);
    end

    // Presents one line and holds it until accepted. Between bursts the
    // sender drops valid for a random gap.
    task automatic send_line(logic [SCORE_BITS-1:0] score, logic [TAG_BITS-1:0] tag,
                             logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(STREAM_BITS - ENTRY_BITS){1'b0}}, tag, score};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_line(score, tag, last);
    endtask

    // Scores drawn often from a few values, so ties are common.
    function automatic logic [SCORE_BITS-1:0] pick_score();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return SCORE_BITS'($urandom_range(0, 3));
            default: return SCORE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_random_set(int unsigned size);
        for (int k = 0; k < size; k++)
            send_line(pick_score(), TAG_BITS'($urandom), k + 1 == size);
    endtask

    initial
    begin
        int unsigned lines_sent;
        int unsigned set_index;
        int unsigned size;
        logic [SCORE_BITS-1:0] tie_scores[5];
        logic [SCORE_BITS-1:0] edge_scores[6];
        logic [TAG_BITS-1:0]   edge_tags[6];

        tie_scores  = '{16'd7, 16'd7, 16'd9, 16'd7, 16'd9};
        edge_scores = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, 16'hFFFF, 16'd0};
        edge_tags   = '{12'hFFF, 12'h000, 12'h800, 12'h001, 12'hAAA, 12'h555};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-line sets at both extremes.
        send_line('1, '1, 1'b1);
        send_line('0, '0, 1'b1);
        // Tied scores with swaps among them.
        for (int k = 0; k < 5; k++)
            send_line(tie_scores[k], TAG_BITS'(10 + k), k == 4);
        // Extreme scores and tags, with a tie at the top and the bottom.
        for (int k = 0; k < 6; k++)
            send_line(edge_scores[k], edge_tags[k], k == 5);

        // Hold the sender until every ranked line has come back.
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (board.outstanding() != 0)
            @(posedge clk);

        // Random sets: first an oversized one whose closing beat is dropped,
        // then a full store, then mostly small sets.
        lines_sent = 0;
        set_index  = 0;
        while (lines_sent < RANDOM_LINES)
        begin
            if (set_index == 0)
                size = $urandom_range(MAX_LINES + 1, MAX_LINES + 4);
            else if (set_index == 1)
                size = MAX_LINES;
            else if ($urandom_range(0, 11) == 0)
                size = $urandom_range(MAX_LINES - 4, MAX_LINES + 6);
            else
                size = $urandom_range(1, 12);
            send_random_set(size);
            lines_sent += size;
            set_index++;
        end

        s_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
